>>> rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is high.
`define AVR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define AVR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/avr_pkg.sv
`timescale 1ns / 1ps
// Package: types, constants and lookup tables of the axis-aligned vector rotator.
package avr_pkg;

   localparam int TRIG_STAGES = 16;

   localparam int COORD_W = 32;
   localparam int ANGLE_W = 24;

   localparam logic [1:0] OP_ROT_X = 2'd0;
   localparam logic [1:0] OP_ROT_Y = 2'd1;
   localparam logic [1:0] OP_ROT_Z = 2'd2;

   // one turn = 92160 units = 45 * 2^11
   localparam int DEG_BIN_DIV = 45;
   localparam int LOW_BITS    = 11;
   localparam int HI_W        = ANGLE_W - LOW_BITS + 1;
   localparam int HI_OFFSET   = 92 * DEG_BIN_DIV;
   localparam int HQ_W        = 8;
   localparam int HQ_SHIFT    = 20;
   localparam int HQ_RECIP_W  = 15;
   localparam int HQ_RECIP    = (2 ** HQ_SHIFT + DEG_BIN_DIV - 1) / DEG_BIN_DIV;
   localparam int HQ_PROD_W   = HI_W + HQ_RECIP_W;
   localparam int RES_W       = 6;
   localparam int RED_W       = RES_W + LOW_BITS;
   localparam int BQ_W        = 11;
   localparam int BQ_SHIFT    = 23;
   localparam int BQ_RECIP_W  = 18;
   localparam int BQ_RECIP    = (2 ** BQ_SHIFT + DEG_BIN_DIV - 1) / DEG_BIN_DIV;
   localparam int BQ_PROD_W   = RED_W + BQ_RECIP_W;
   localparam int FRAC_W      = 21;
   localparam int BIN_W       = BQ_W + FRAC_W;
   localparam logic signed [BIN_W-1:0] BIN_QUARTER = 32'sd1073741824;

   localparam int CD_W   = 34;
   localparam int Z_W    = 33;
   localparam int ATAN_W = 30;
   localparam int TRIG_W = 32;
   localparam logic signed [CD_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CD_W-1:0] ONE_Q30     = 34'sd1073741824;

   localparam int PROD_W     = 2 * COORD_W;
   localparam int ACC_W      = PROD_W + 1;
   localparam int FRAC_SHIFT = 30;

   localparam logic [ATAN_W-1:0] ATAN_LUT [32] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
      30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
   };

   // fraction of a 45-unit residue in binary-angle units, rounded
   typedef logic [2**RES_W-1:0][FRAC_W-1:0] frac_lut_type;

   function automatic frac_lut_type build_frac_lut();
      frac_lut_type lut;
      lut = '0;
      for (int i = 0; i < DEG_BIN_DIV; i++) begin
         lut[i] = FRAC_W'(((longint'(i) << FRAC_W) + longint'(DEG_BIN_DIV / 2))
                          / DEG_BIN_DIV);
      end
      return lut;
   endfunction

   localparam frac_lut_type FRAC_LUT = build_frac_lut();

   typedef struct packed {
      logic [1:0]                op;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                op;
      logic                      bypass;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } ctx_type;

   typedef struct packed {
      ctx_type               ctx;
      logic                  flip;
      logic signed [Z_W-1:0] z;
   } ang_type;

   typedef struct packed {
      ctx_type                ctx;
      logic                   flip;
      logic signed [CD_W-1:0] x;
      logic signed [CD_W-1:0] y;
   } trig_type;

   typedef struct packed {
      ctx_type                ctx;
      logic                   flip;
      logic signed [CD_W-1:0] x;
      logic signed [CD_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cd_type;

endpackage

>>> rtl/avr_angle.sv
`timescale 1ns / 1ps
// Angle front end: modulo-one-turn reduction and conversion to a binary angle, three stages.
module avr_angle (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  avr_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output avr_pkg::ang_type out_data
);
   import avr_pkg::*;

   logic [2:0] valid_ff;
   logic [2:0] adv;

   ctx_type           ctx_a_ff, ctx_b_ff;
   logic [HI_W-1:0]   hi_a_ff;
   logic [LOW_BITS-1:0] lo_a_ff;
   logic [HQ_W-1:0]   hq_a_ff;
   logic [RED_W-1:0]  red_b_ff;
   logic [BQ_W-1:0]   bq_b_ff;
   ang_type           ang_c_ff;

   ctx_type              ctx_in;
   logic [HI_W-1:0]      hi_in;
   logic [HQ_PROD_W-1:0] hq_prod;
   logic [HQ_W-1:0]      hq_in;
   logic [HI_W-1:0]      hm_full;
   logic [RED_W-1:0]     red_in;
   logic [BQ_PROD_W-1:0] bq_prod;
   logic [BQ_W-1:0]      bq_in;
   logic [RED_W-1:0]     rem_full;
   logic [RES_W-1:0]     res;
   logic [BIN_W-1:0]     bin;
   logic                 flip_in;
   ang_type              ang_in;

   assign adv[2]   = !valid_ff[2] || out_ready;
   assign adv[1]   = !valid_ff[1] || adv[2];
   assign adv[0]   = !valid_ff[0] || adv[1];
   assign in_ready = adv[0];

   // stage A: high part of the angle, its quotient by 45
   always_comb begin
      ctx_in.op     = in_data.op;
      ctx_in.bypass = (in_data.angle == '0) ||
                      !((in_data.op == OP_ROT_X) || (in_data.op == OP_ROT_Y) ||
                        (in_data.op == OP_ROT_Z));
      ctx_in.x      = in_data.in_x;
      ctx_in.y      = in_data.in_y;
      ctx_in.z      = in_data.in_z;
   end

   assign hi_in   = {in_data.angle[ANGLE_W-1], in_data.angle[ANGLE_W-1:LOW_BITS]}
                    + HI_W'(HI_OFFSET);
   assign hq_prod = HQ_PROD_W'(hi_in) * HQ_PROD_W'(HQ_RECIP);
   assign hq_in   = hq_prod[HQ_SHIFT +: HQ_W];

   // stage B: angle mod one turn, its quotient by 45
   assign hm_full = hi_a_ff - HI_W'(hq_a_ff) * HI_W'(DEG_BIN_DIV);
   assign red_in  = {hm_full[RES_W-1:0], lo_a_ff};
   assign bq_prod = BQ_PROD_W'(red_in) * BQ_PROD_W'(BQ_RECIP);
   assign bq_in   = bq_prod[BQ_SHIFT +: BQ_W];

   // stage C: binary angle, folded into the right half plane
   assign rem_full = red_b_ff - RED_W'(bq_b_ff) * RED_W'(DEG_BIN_DIV);
   assign res      = rem_full[RES_W-1:0];
   assign bin      = {bq_b_ff, FRAC_LUT[res]};
   assign flip_in  = ($signed(bin) > BIN_QUARTER) || ($signed(bin) < -BIN_QUARTER);

   always_comb begin
      ang_in.ctx  = ctx_b_ff;
      ang_in.flip = flip_in;
      ang_in.z    = Z_W'($signed(flip_in ? {~bin[BIN_W-1], bin[BIN_W-2:0]} : bin));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         if (adv[1]) valid_ff[1] <= valid_ff[0];
         if (adv[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ctx_a_ff <= ctx_in;
         hi_a_ff  <= hi_in;
         lo_a_ff  <= in_data.angle[LOW_BITS-1:0];
         hq_a_ff  <= hq_in;
      end
      if (adv[1]) begin
         ctx_b_ff <= ctx_a_ff;
         red_b_ff <= red_in;
         bq_b_ff  <= bq_in;
      end
      if (adv[2]) begin
         ang_c_ff <= ang_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = ang_c_ff;

endmodule

>>> rtl/avr_cordic.sv
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one registered micro-rotation per stage.
module avr_cordic (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  avr_pkg::ang_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output avr_pkg::trig_type out_data
);
   import avr_pkg::*;

   cd_type stage_ff [TRIG_STAGES];
   logic   valid_ff [TRIG_STAGES];
   wire    [TRIG_STAGES:0] adv;
   cd_type seed;

   always_comb begin
      seed.ctx  = in_data.ctx;
      seed.flip = in_data.flip;
      seed.x    = CORDIC_GAIN;
      seed.y    = '0;
      seed.z    = in_data.z;
   end

   assign adv[TRIG_STAGES] = out_ready;
   assign in_ready         = adv[0];

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
      cd_type                 src;
      cd_type                 nxt;
      logic                   src_valid;
      logic signed [CD_W-1:0] dx;
      logic signed [CD_W-1:0] dy;

      if (i == 0) begin : g_first
         assign src       = seed;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = stage_ff[i-1];
         assign src_valid = valid_ff[i-1];
      end

      assign adv[i] = !valid_ff[i] || adv[i+1];
      assign dx     = $signed(src.y) >>> i;
      assign dy     = $signed(src.x) >>> i;

      always_comb begin
         nxt = src;
         if (!src.z[Z_W-1]) begin
            nxt.x = src.x - dx;
            nxt.y = src.y + dy;
            nxt.z = src.z - Z_W'(ATAN_LUT[i]);
         end else begin
            nxt.x = src.x + dx;
            nxt.y = src.y - dy;
            nxt.z = src.z + Z_W'(ATAN_LUT[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (adv[i]) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[i]) begin
            stage_ff[i] <= nxt;
         end
      end
   end

   assign out_valid     = valid_ff[TRIG_STAGES-1];
   assign out_data.ctx  = stage_ff[TRIG_STAGES-1].ctx;
   assign out_data.flip = stage_ff[TRIG_STAGES-1].flip;
   assign out_data.x    = stage_ff[TRIG_STAGES-1].x;
   assign out_data.y    = stage_ff[TRIG_STAGES-1].y;

endmodule

>>> rtl/avr_mix.sv
`timescale 1ns / 1ps
// Back end: sine/cosine clamp, coordinate products, rounding, saturation, output register.
module avr_mix (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  avr_pkg::trig_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output avr_pkg::rsp_type  out_data
);
   import avr_pkg::*;

   logic    v1_ff, v2_ff, rsp_valid_ff;
   logic    adv1, adv2, adv3;

   ctx_type                   ctx1_ff, ctx2_ff;
   logic signed [TRIG_W-1:0]  cos1_ff, sin1_ff;
   logic signed [COORD_W-1:0] pa1_ff, pb1_ff;
   logic signed [PROD_W-1:0]  pac_ff, pbs_ff, pas_ff, pbc_ff;
   rsp_type                   rsp_data_ff;

   logic signed [CD_W-1:0]    cx, sy;
   logic signed [TRIG_W-1:0]  cos_in, sin_in;
   logic signed [COORD_W-1:0] pa_in, pb_in;
   logic signed [ACC_W-1:0]   acc_a, acc_b;
   logic signed [COORD_W-1:0] na, nb;
   rsp_type                   rsp_in;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);

   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0]   sh;
      logic signed [COORD_W-1:0] r;
      sh = acc >>> FRAC_SHIFT;
      if ((sh[ACC_W-1:COORD_W-1] == '0) || (sh[ACC_W-1:COORD_W-1] == '1)) begin
         r = sh[COORD_W-1:0];
      end else if (sh[ACC_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

   assign adv3     = !rsp_valid_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   // stage 1: clamp, quadrant fold, axis selection
   always_comb begin
      cx = in_data.x;
      if (cx > ONE_Q30) begin
         cx = ONE_Q30;
      end else if (cx < -ONE_Q30) begin
         cx = -ONE_Q30;
      end
      sy = in_data.y;
      if (sy > ONE_Q30) begin
         sy = ONE_Q30;
      end else if (sy < -ONE_Q30) begin
         sy = -ONE_Q30;
      end
      cos_in = TRIG_W'(in_data.flip ? -cx : cx);
      // Y axis runs the same form with the sine negated
      sin_in = TRIG_W'((in_data.flip ^ (in_data.ctx.op == OP_ROT_Y)) ? -sy : sy);
      case (in_data.ctx.op)
         OP_ROT_X: begin
            pa_in = in_data.ctx.y;
            pb_in = in_data.ctx.z;
         end
         OP_ROT_Y: begin
            pa_in = in_data.ctx.x;
            pb_in = in_data.ctx.z;
         end
         default: begin
            pa_in = in_data.ctx.x;
            pb_in = in_data.ctx.y;
         end
      endcase
   end

   // stage 3: recombine, round, saturate
   assign acc_a = ACC_W'(pac_ff) - ACC_W'(pbs_ff) + ROUND_HALF;
   assign acc_b = ACC_W'(pas_ff) + ACC_W'(pbc_ff) + ROUND_HALF;
   assign na    = sat_coord(acc_a);
   assign nb    = sat_coord(acc_b);

   always_comb begin
      rsp_in.out_x = ctx2_ff.x;
      rsp_in.out_y = ctx2_ff.y;
      rsp_in.out_z = ctx2_ff.z;
      if (!ctx2_ff.bypass) begin
         case (ctx2_ff.op)
            OP_ROT_X: begin
               rsp_in.out_y = na;
               rsp_in.out_z = nb;
            end
            OP_ROT_Y: begin
               rsp_in.out_x = na;
               rsp_in.out_z = nb;
            end
            OP_ROT_Z: begin
               rsp_in.out_x = na;
               rsp_in.out_y = nb;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         ctx1_ff <= in_data.ctx;
         cos1_ff <= cos_in;
         sin1_ff <= sin_in;
         pa1_ff  <= pa_in;
         pb1_ff  <= pb_in;
      end
      if (adv2) begin
         ctx2_ff <= ctx1_ff;
         pac_ff  <= PROD_W'(pa1_ff) * PROD_W'(cos1_ff);
         pbs_ff  <= PROD_W'(pb1_ff) * PROD_W'(sin1_ff);
         pas_ff  <= PROD_W'(pa1_ff) * PROD_W'(sin1_ff);
         pbc_ff  <= PROD_W'(pb1_ff) * PROD_W'(cos1_ff);
      end
      if (adv3) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_data_ff;

endmodule

>>> rtl/axis_aligned_vector_rotator.sv
`timescale 1ns / 1ps
// Top level: rotates a Q16.16 point about the X, Y or Z axis by an angle in 1/256 degree.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  avr_pkg::req_type (op, angle, in_x..in_z)
//   rsp      out        rsp_valid / rsp_ready  avr_pkg::rsp_type (out_x..out_z)
//
// One transaction per cycle while the output is not stalled; the path runs through the angle
// front end, the chain of CORDIC micro-rotation stages and the back end.
// Reset clears every stage valid bit; payload registers are not reset.
// A stalled result holds in the output register while earlier stages keep closing
// bubbles; req_ready drops only once every stage holds a transaction.
module axis_aligned_vector_rotator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  avr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output avr_pkg::rsp_type rsp_data
);
   import avr_pkg::*;

   logic     ang_valid, ang_ready;
   ang_type  ang_data;
   logic     trig_valid, trig_ready;
   trig_type trig_data;

   avr_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (ang_valid),
      .out_ready (ang_ready),
      .out_data  (ang_data)
   );

   avr_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ang_valid),
      .in_ready  (ang_ready),
      .in_data   (ang_data),
      .out_valid (trig_valid),
      .out_ready (trig_ready),
      .out_data  (trig_data)
   );

   avr_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (trig_valid),
      .in_ready  (trig_ready),
      .in_data   (trig_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

>>> rtl/avr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the rotator, bound to the top level.
`include "assert_macros.svh"

module avr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input avr_pkg::rsp_type rsp_data
);
   import avr_pkg::*;

   `AVR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")
   `AVR_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_data), "stalled result changed")
   `AVR_ASSERT(a_ready_when_drained, !rsp_valid |-> req_ready, "input blocked with output empty")
   `AVR_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "result present after reset")

endmodule

bind axis_aligned_vector_rotator avr_checker u_avr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
